### hw/rtl/csvft_pkg.sv
// csvft_pkg: shared types and codes for the csv field tokenizer
`timescale 1ns / 1ps

package csvft_pkg;

   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_PLAIN   = 3'd1;
   localparam logic [2:0] PH_QUOTED  = 3'd2;
   localparam logic [2:0] PH_CLOSED  = 3'd3;
   localparam logic [2:0] PH_SPACES  = 3'd4;
   localparam logic [2:0] PH_ESCAPE  = 3'd5;
   localparam logic [2:0] PH_COMMENT = 3'd6;
   localparam logic [2:0] PH_SWALLOW = 3'd7;

   localparam logic [2:0] CSR_DELIMITER    = 3'd0;
   localparam logic [2:0] CSR_QUOTE        = 3'd1;
   localparam logic [2:0] CSR_COMMENT      = 3'd2;
   localparam logic [2:0] CSR_ESCAPE       = 3'd3;
   localparam logic [2:0] CSR_SKIP_SPACES  = 3'd4;
   localparam logic [2:0] CSR_SKIP_BLANK   = 3'd5;
   localparam logic [2:0] CSR_SKIP_COMMENT = 3'd6;

   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;
   localparam logic [7:0] COMMENT_RESET   = 8'd35;
   localparam logic [7:0] ESCAPE_RESET    = 8'd92;

   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] BYTE_NUL   = 8'd0;
   localparam logic [7:0] BYTE_SPACE = 8'd32;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       field_done;
      logic       row_done;
   } result_type;

endpackage

### hw/rtl/csv_field_tokenizer_top.sv
// csv_field_tokenizer_top: byte-wide csv tokenizer with skid-buffered result channel
`timescale 1ns / 1ps

// Takes one byte of CSV text (or an end-of-stream mark) per item and returns exactly one
// result item per input item: an optional field byte with quotes and escapes removed, and
// field-end and row-end flags. The parser state is a single register stage updated at
// acceptance, so one item is accepted every cycle while req_stall is low. Its result is
// registered into the output register or the one skid entry behind it; req_stall rises only
// when both hold results that have not been taken. Configuration registers are written
// through the csr_ port, which is always ready, and must only change while the block is idle.
module csv_field_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_out,
   output logic       rsp_field_done,
   output logic       rsp_row_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import csvft_pkg::*;

   logic [7:0] delimiter_ff, quote_ff, comment_ff, escape_ff;
   logic       skip_spaces_ff, skip_blank_ff, skip_comment_ff;

   logic [2:0] phase_ff, phase_in;
   logic       row_started_ff, row_started_in;
   logic       has_chars_ff, has_chars_in;

   result_type out_ff, skid_ff, result_in;
   logic       out_valid_ff, skid_valid_ff;

   logic accept, take;
   logic term, delim, quote, space, comment;
   logic emit, close_req;
   logic [2:0] ph;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff    <= DELIMITER_RESET;
         quote_ff        <= QUOTE_RESET;
         comment_ff      <= COMMENT_RESET;
         escape_ff       <= ESCAPE_RESET;
         skip_spaces_ff  <= 1'b0;
         skip_blank_ff   <= 1'b0;
         skip_comment_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELIMITER:    delimiter_ff    <= csr_data;
            CSR_QUOTE:        quote_ff        <= csr_data;
            CSR_COMMENT:      comment_ff      <= csr_data;
            CSR_ESCAPE:       escape_ff       <= csr_data;
            CSR_SKIP_SPACES:  skip_spaces_ff  <= csr_data[0];
            CSR_SKIP_BLANK:   skip_blank_ff   <= csr_data[0];
            CSR_SKIP_COMMENT: skip_comment_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // byte classification
   always_comb begin
      term    = (req_text_byte == BYTE_CR) || (req_text_byte == BYTE_LF) ||
                (req_text_byte == BYTE_NUL);
      delim   = (req_text_byte == delimiter_ff);
      quote   = (req_text_byte == quote_ff);
      space   = (req_text_byte == BYTE_SPACE);
      comment = skip_comment_ff && !row_started_ff && (req_text_byte == comment_ff);
   end

   // next state and result
   always_comb begin
      result_in      = '0;
      phase_in       = phase_ff;
      row_started_in = row_started_ff;
      has_chars_in   = has_chars_ff;
      emit           = 1'b0;
      close_req      = 1'b0;
      ph             = phase_ff;

      if (req_end_of_stream) begin
         if (phase_ff != PH_COMMENT && phase_ff != PH_SWALLOW &&
             (row_started_ff || has_chars_ff)) begin
            result_in.field_done = 1'b1;
            result_in.row_done   = 1'b1;
         end
         phase_in       = PH_START;
         row_started_in = 1'b0;
         has_chars_in   = 1'b0;
      end else if (phase_ff == PH_SWALLOW && term) begin
         phase_in = PH_START;
      end else begin
         if (phase_ff == PH_SWALLOW) begin
            ph = PH_START;
         end
         phase_in = ph;
         case (ph)
            PH_START: begin
               if (quote) phase_in = PH_QUOTED;
               else if (skip_spaces_ff && space) phase_in = PH_SPACES;
               else if (delim || term) close_req = 1'b1;
               else if (comment) phase_in = PH_COMMENT;
               else begin
                  emit     = 1'b1;
                  phase_in = PH_PLAIN;
               end
            end
            PH_SPACES: begin
               if (quote) phase_in = PH_QUOTED;
               else if (delim || term) close_req = 1'b1;
               else if (space) phase_in = PH_SPACES;
               else if (comment) phase_in = PH_COMMENT;
               else begin
                  emit     = 1'b1;
                  phase_in = PH_PLAIN;
               end
            end
            PH_QUOTED: begin
               if (quote) phase_in = PH_CLOSED;
               else if (req_text_byte == escape_ff) phase_in = PH_ESCAPE;
               else emit = 1'b1;
            end
            PH_ESCAPE: begin
               emit     = 1'b1;
               phase_in = PH_QUOTED;
            end
            PH_CLOSED: begin
               if (quote) begin
                  emit     = 1'b1;
                  phase_in = PH_QUOTED;
               end else if (delim || term) begin
                  close_req = 1'b1;
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_PLAIN;
               end
            end
            PH_PLAIN: begin
               if (delim || term) close_req = 1'b1;
               else emit = 1'b1;
            end
            PH_COMMENT: begin
               if (term) phase_in = PH_SWALLOW;
            end
            default: phase_in = PH_START;
         endcase

         if (emit) begin
            result_in.char_valid = 1'b1;
            result_in.char_out   = req_text_byte;
            has_chars_in         = 1'b1;
         end

         if (close_req) begin
            if (!term) begin
               result_in.field_done = 1'b1;
               row_started_in       = 1'b1;
               phase_in             = PH_START;
            end else begin
               if (skip_blank_ff && !row_started_ff && !has_chars_ff) begin
                  phase_in = PH_START;
               end else begin
                  result_in.field_done = 1'b1;
                  result_in.row_done   = 1'b1;
                  phase_in             = PH_SWALLOW;
               end
               row_started_in = 1'b0;
            end
            has_chars_in = 1'b0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         row_started_ff <= 1'b0;
         has_chars_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         row_started_ff <= row_started_in;
         has_chars_ff   <= has_chars_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_valid_ff ? skid_ff : result_in;
      end else if (accept) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_valid = out_ff.char_valid;
   assign rsp_char_out   = out_ff.char_out;
   assign rsp_field_done = out_ff.field_done;
   assign rsp_row_done   = out_ff.row_done;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while output register is empty");

   a_byte_or_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_valid) |-> (!rsp_field_done && !rsp_row_done))
      else $error("item gives a byte and a field end together");

   a_row_implies_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_done) |-> rsp_field_done)
      else $error("row end without field end");

   a_swallow_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SWALLOW) |-> (!row_started_ff && !has_chars_ff))
      else $error("swallow phase with row or field state pending");

   a_zero_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> (rsp_char_out == 8'd0))
      else $error("char_out not zero without a byte");

endmodule
